### design/sfla_pkg.sv
// Package for the size-class free-list allocator: pool geometry, derived
// widths, result codes and the list link type.
// Depends on nothing; imported by size_class_free_list_allocator.
package sfla_pkg;

    // Pool geometry
    localparam int NUM_CHUNKS       = 64;
    localparam int BLOCKS_PER_CHUNK = 64;
    localparam int TOTAL_BLOCKS     = NUM_CHUNKS * BLOCKS_PER_CHUNK;

    // Size classes
    localparam int NUM_CLASSES = 19;
    localparam int TOP_CLASS   = 18;
    localparam int CLASS_W     = 5;

    // Field and index widths
    localparam int HANDLE_W = 12;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int LINK_W   = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int CHUNK_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int USED_W   = $clog2(NUM_CHUNKS + 1);
    localparam int SLOT_W   = $clog2(BLOCKS_PER_CHUNK);

    // Largest size served from the size classes
    localparam logic [SIZE_W-1:0] MAX_SMALL = 32'd1024;

    // Handle to chunk: multiply by a floor reciprocal, then one correction.
    localparam int DIV_SHIFT = 20;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / BLOCKS_PER_CHUNK;
    localparam int RECIP_W   = DIV_SHIFT;
    localparam int PROD_W    = HANDLE_W + RECIP_W;
    localparam int REM_W     = HANDLE_W + 9;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LARGE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMEM      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NULL       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_LARGE_FREE = 3'd6;

    // A list link: block index plus an end-of-list flag.
    typedef struct packed {
        logic              empty;
        logic [LINK_W-1:0] idx;
    } t_link;

endpackage

### design/sfla_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the link store and the chunk owner store.
module sfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/size_class_free_list_allocator.sv
// Size-class free-list allocator: top level with the sequencer, class heads
// and result register. Depends on sfla_pkg and sfla_ram.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+--------------------------------------------
//   request  | i_in_valid   | o_in_ready   | i_cmd, i_req_size, i_handle_present,
//            |              |              | i_free_handle
//   result   | o_out_valid  | i_out_ready  | o_status, o_grant_handle, o_grant_class
//
// A request is taken only while the sequencer is idle. Zero-size, large and
// null requests go from decode straight to the result; a free runs the divide,
// check, owner-read and push states; an allocate examines class heads in turn
// (1 to 19) through the single head-read port of the class search. Carving a
// chunk writes a link per block (64) through the link RAM's one write port.
// Reset empties all class lists and the chunk count; no clearing pass runs.
// A finished result waits in the output register; a new request may be taken
// meanwhile, and the next result holds in the sequencer until the slot frees.
module size_class_free_list_allocator
    import sfla_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [SIZE_W-1:0]   i_req_size,
    input  logic                i_handle_present,
    input  logic [HANDLE_W-1:0] i_free_handle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_grant_handle,
    output logic [CLASS_W-1:0]  o_grant_class
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_SEARCH  = 4'd2;
    localparam logic [3:0] S_CARVE   = 4'd3;
    localparam logic [3:0] S_POP     = 4'd4;
    localparam logic [3:0] S_POPWAIT = 4'd5;
    localparam logic [3:0] S_FDIV    = 4'd6;
    localparam logic [3:0] S_FCHK    = 4'd7;
    localparam logic [3:0] S_FOWN    = 4'd8;
    localparam logic [3:0] S_FPUSH   = 4'd9;
    localparam logic [3:0] S_RESULT  = 4'd10;

    logic [3:0]          r_state, n_state;
    logic                r_cmd, n_cmd;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_present, n_present;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [CLASS_W-1:0]  r_k, n_k;
    logic [CLASS_W-1:0]  r_q, n_q;
    logic [USED_W-1:0]   r_used, n_used;
    t_link               r_head [NUM_CLASSES];
    t_link               n_head [NUM_CLASSES];
    logic [LINK_W-1:0]   r_link_ptr, n_link_ptr;
    logic [LINK_W-1:0]   r_base, n_base;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [HANDLE_W-1:0] r_est, n_est;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [CLASS_W-1:0]  r_res_class, n_res_class;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [CLASS_W-1:0]  r_out_class, n_out_class;

    // RAM ports
    logic               link_we;
    logic [LINK_W-1:0]  link_waddr;
    t_link              link_wdata;
    logic [LINK_W-1:0]  link_raddr;
    t_link              link_rdata;
    logic               own_we;
    logic [CHUNK_W-1:0] own_waddr;
    logic [CLASS_W-1:0] own_wdata;
    logic [CHUNK_W-1:0] own_raddr;
    logic [CLASS_W-1:0] own_rdata;

    // Helper values
    t_link               head_q;
    logic [10:0]         size_m1;
    logic [CLASS_W-1:0]  size_class;
    logic [31:0]         base_full;
    logic                slot_last;
    logic [PROD_W-1:0]   est_prod;
    logic [REM_W-1:0]    back_prod;
    logic [REM_W-1:0]    div_rem;
    logic [HANDLE_W-1:0] chunk;
    logic                handle_ok;
    logic                chunk_ok;
    logic [31:0]         handle_wide;
    logic [31:0]         grant_wide;
    logic [CLASS_W-1:0]  owner_cls;

    sfla_ram #(
        .WIDTH ($bits(t_link)),
        .DEPTH (TOTAL_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    sfla_ram #(
        .WIDTH (CLASS_W),
        .DEPTH (NUM_CHUNKS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    assign head_q = r_head[r_q];

    // Sizes of 1 to 256 map to (size - 1) / 16; above that, three wide classes.
    assign size_m1 = r_size[10:0] - 11'd1;
    always_comb begin
        if (r_size <= 32'd256) begin
            size_class = {1'b0, size_m1[7:4]};
        end else if (r_size <= 32'd512) begin
            size_class = CLASS_W'(16);
        end else if (r_size <= 32'd768) begin
            size_class = CLASS_W'(17);
        end else begin
            size_class = CLASS_W'(TOP_CLASS);
        end
    end

    assign base_full = 32'(r_used) * 32'(BLOCKS_PER_CHUNK);
    assign slot_last = (r_slot == SLOT_W'(BLOCKS_PER_CHUNK - 1));

    // The reciprocal estimate is never high and at most one low.
    assign est_prod  = PROD_W'(r_handle) * PROD_W'(DIV_RECIP);
    assign back_prod = REM_W'(r_est) * REM_W'(BLOCKS_PER_CHUNK);
    assign div_rem   = REM_W'(r_handle) - back_prod;
    assign chunk     = r_est + HANDLE_W'(div_rem >= REM_W'(BLOCKS_PER_CHUNK));
    assign handle_ok = (32'(r_handle) < 32'(TOTAL_BLOCKS));
    assign chunk_ok  = (32'(chunk) < 32'(r_used));

    assign handle_wide = 32'(r_handle);
    assign grant_wide  = 32'(head_q.idx);
    assign owner_cls   = (own_rdata > CLASS_W'(TOP_CLASS)) ? CLASS_W'(TOP_CLASS) : own_rdata;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_present    = r_present;
        n_handle     = r_handle;
        n_k          = r_k;
        n_q          = r_q;
        n_used       = r_used;
        n_head       = r_head;
        n_link_ptr   = r_link_ptr;
        n_base       = r_base;
        n_slot       = r_slot;
        n_est        = r_est;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_class  = r_res_class;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_class  = r_out_class;

        link_we    = 1'b0;
        link_waddr = r_link_ptr;
        link_wdata = '0;
        link_raddr = head_q.idx;
        own_we     = 1'b0;
        own_waddr  = r_used[CHUNK_W-1:0];
        own_wdata  = r_k;
        own_raddr  = chunk[CHUNK_W-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_cmd;
                    n_size    = i_req_size;
                    n_present = i_handle_present;
                    n_handle  = i_free_handle;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_handle = '0;
                n_res_class  = '0;
                if (!r_cmd) begin
                    if (r_size == '0) begin
                        n_res_status = ST_ZERO;
                        n_state      = S_RESULT;
                    end else if (r_size > MAX_SMALL) begin
                        n_res_status = ST_LARGE;
                        n_state      = S_RESULT;
                    end else begin
                        n_k     = size_class;
                        n_q     = size_class;
                        n_state = S_SEARCH;
                    end
                end else begin
                    if (!r_present) begin
                        n_res_status = ST_NULL;
                        n_state      = S_RESULT;
                    end else if (r_size > MAX_SMALL) begin
                        n_res_status = ST_LARGE_FREE;
                        n_state      = S_RESULT;
                    end else begin
                        n_state = S_FDIV;
                    end
                end
            end
            S_SEARCH: begin
                // Walk up one class head per cycle until a list holds a block.
                if (!head_q.empty) begin
                    n_state = S_POP;
                end else if (r_q < CLASS_W'(TOP_CLASS)) begin
                    n_q = r_q + CLASS_W'(1);
                end else if (32'(r_used) >= 32'(NUM_CHUNKS)) begin
                    n_res_status = ST_NOMEM;
                    n_state      = S_RESULT;
                end else begin
                    own_we     = 1'b1;
                    n_q        = r_k;
                    n_base     = base_full[LINK_W-1:0];
                    n_link_ptr = base_full[LINK_W-1:0];
                    n_slot     = '0;
                    n_state    = S_CARVE;
                end
            end
            S_CARVE: begin
                // Chain the new chunk's blocks, one link per cycle.
                link_we          = 1'b1;
                link_waddr       = r_link_ptr;
                link_wdata.empty = slot_last;
                link_wdata.idx   = slot_last ? '0 : r_link_ptr + LINK_W'(1);
                n_link_ptr       = r_link_ptr + LINK_W'(1);
                n_slot           = r_slot + SLOT_W'(1);
                if (slot_last) begin
                    n_head[r_q].empty = 1'b0;
                    n_head[r_q].idx   = r_base;
                    n_used            = r_used + USED_W'(1);
                    n_state           = S_POP;
                end
            end
            S_POP: begin
                link_raddr = head_q.idx;
                n_state    = S_POPWAIT;
            end
            S_POPWAIT: begin
                n_head[r_q]  = link_rdata;
                n_res_status = ST_GRANTED;
                n_res_handle = grant_wide[HANDLE_W-1:0];
                n_res_class  = r_q;
                n_state      = S_RESULT;
            end
            S_FDIV: begin
                n_est   = est_prod[PROD_W-1:DIV_SHIFT];
                n_state = S_FCHK;
            end
            S_FCHK: begin
                own_raddr = chunk[CHUNK_W-1:0];
                if (handle_ok && chunk_ok) begin
                    n_state = S_FOWN;
                end else begin
                    n_res_status = ST_NULL;
                    n_state      = S_RESULT;
                end
            end
            S_FOWN: begin
                n_q     = owner_cls;
                n_state = S_FPUSH;
            end
            S_FPUSH: begin
                link_we           = 1'b1;
                link_waddr        = handle_wide[LINK_W-1:0];
                link_wdata        = head_q;
                n_head[r_q].empty = 1'b0;
                n_head[r_q].idx   = handle_wide[LINK_W-1:0];
                n_res_status      = ST_FREED;
                n_state           = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_class  = r_res_class;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i] <= '{empty: 1'b1, idx: '0};
            end
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
        end
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_present    <= n_present;
        r_handle     <= n_handle;
        r_k          <= n_k;
        r_q          <= n_q;
        r_link_ptr   <= n_link_ptr;
        r_base       <= n_base;
        r_slot       <= n_slot;
        r_est        <= n_est;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_class  <= n_res_class;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_class  <= n_out_class;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_grant_handle = r_out_handle;
    assign o_grant_class  = r_out_class;

endmodule

### tb/sv/free_list_checker.sv
`timescale 1ns / 100ps
// Request codes shared by the testbench, plus the checker that predicts and compares
// every result of the size-class free-list allocator. Depends on sfla_pkg.
package alloc_tb_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

module free_list_checker
    import sfla_pkg::*;
    import alloc_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic                i_cmd,
    input  logic [SIZE_W-1:0]   i_req_size,
    input  logic                i_handle_present,
    input  logic [HANDLE_W-1:0] i_free_handle,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [HANDLE_W-1:0] i_grant_handle,
    input  logic [CLASS_W-1:0]  i_grant_class,
    output int                  o_fail_count,
    output int                  o_outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [CLASS_W-1:0]  cls;
    } t_alloc_result;

    // Shadow copy of the allocator's lists.
    t_link              free_head   [NUM_CLASSES];
    t_link              next_block  [TOTAL_BLOCKS];
    logic [CLASS_W-1:0] owner_class [NUM_CHUNKS];
    int unsigned        carved_chunks;

    t_alloc_result      expected_results [$];
    int                 mismatch_count = 0;
    int                 queued_count   = 0;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = queued_count;

    function automatic t_alloc_result predict_request(
        input logic                cmd,
        input logic [SIZE_W-1:0]   sz,
        input logic                present,
        input logic [HANDLE_W-1:0] h
    );
        t_alloc_result res;
        int unsigned   want_cls;
        int unsigned   cls;
        int unsigned   base;
        int unsigned   chunk;
        int            i;
        res = '0;
        if (cmd == CMD_ALLOC) begin
            if (sz == '0) begin
                res.status = ST_ZERO;
            end else if (sz > MAX_SMALL) begin
                res.status = ST_LARGE;
            end else begin
                // Classes step by 16 bytes up to 256, then by 256 up to 1024.
                if (sz <= 32'd256) begin
                    want_cls = (sz + 15) / 16 - 1;
                end else if (sz <= 32'd512) begin
                    want_cls = 16;
                end else if (sz <= 32'd768) begin
                    want_cls = 17;
                end else begin
                    want_cls = TOP_CLASS;
                end
                cls = want_cls;
                while (cls < TOP_CLASS && free_head[cls].empty) begin
                    cls++;
                end
                if (free_head[cls].empty) begin
                    cls = want_cls;
                    if (carved_chunks >= NUM_CHUNKS) begin
                        res.status = ST_NOMEM;
                        return res;
                    end
                    // A new chunk becomes one linked list owned by the requested class.
                    base = carved_chunks * BLOCKS_PER_CHUNK;
                    owner_class[carved_chunks] = CLASS_W'(cls);
                    for (i = 0; i < BLOCKS_PER_CHUNK - 1; i++) begin
                        next_block[base + i] = '{empty: 1'b0, idx: LINK_W'(base + i + 1)};
                    end
                    next_block[base + BLOCKS_PER_CHUNK - 1] = '{empty: 1'b1, idx: '0};
                    free_head[cls] = '{empty: 1'b0, idx: LINK_W'(base)};
                    carved_chunks++;
                end
                res.status     = ST_GRANTED;
                res.handle     = HANDLE_W'(free_head[cls].idx);
                res.cls        = CLASS_W'(cls);
                free_head[cls] = next_block[free_head[cls].idx];
            end
        end else if (!present) begin
            res.status = ST_NULL;
        end else if (sz > MAX_SMALL) begin
            res.status = ST_LARGE_FREE;
        end else begin
            chunk = h / BLOCKS_PER_CHUNK;
            // Handles outside the carved chunks are dropped like a null free.
            if (h >= TOTAL_BLOCKS || chunk >= carved_chunks) begin
                res.status = ST_NULL;
            end else begin
                cls            = 32'(owner_class[chunk]);
                next_block[h]  = free_head[cls];
                free_head[cls] = '{empty: 1'b0, idx: LINK_W'(h)};
                res.status     = ST_FREED;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_result wanted;
        int            c;
        if (!i_rst_n) begin
            for (c = 0; c < NUM_CLASSES; c++) begin
                free_head[c] = '{empty: 1'b1, idx: '0};
            end
            carved_chunks = 0;
            expected_results.delete();
        end else begin
            // The result side goes first: a result never belongs to a request taken
            // at the same edge.
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected: status %0d handle %0d class %0d",
                             $time, i_status, i_grant_handle, i_grant_class);
                end else begin
                    wanted = expected_results.pop_front();
                    if (i_status !== wanted.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, wanted.status, i_status);
                    end
                    if (i_grant_handle !== wanted.handle) begin
                        mismatch_count++;
                        $display("%0t: grant_handle expected %0d, got %0d",
                                 $time, wanted.handle, i_grant_handle);
                    end
                    if (i_grant_class !== wanted.cls) begin
                        mismatch_count++;
                        $display("%0t: grant_class expected %0d, got %0d",
                                 $time, wanted.cls, i_grant_class);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(predict_request(i_cmd, i_req_size,
                                                           i_handle_present, i_free_handle));
            end
        end
        queued_count = expected_results.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request stimulus and result-side
// stalls. Depends on sfla_pkg, alloc_tb_pkg and free_list_checker.
module tb;
    import sfla_pkg::*;
    import alloc_tb_pkg::*;

    localparam int DIRECTED_PHASE_LEN = 200;
    localparam int MAX_GAP            = 12;
    localparam int LONG_HOLD          = 400;
    localparam int RANDOM_ITEMS       = 1235;
    localparam int DRAIN_ITEMS        = 10 * BLOCKS_PER_CHUNK;
    localparam int SETTLE_CYCLES      = 120;
    localparam int TIMEOUT_NS         = 4000000;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_in_valid       = 1'b0;
    logic                i_cmd            = CMD_ALLOC;
    logic [SIZE_W-1:0]   i_req_size       = '0;
    logic                i_handle_present = 1'b0;
    logic [HANDLE_W-1:0] i_free_handle    = '0;
    logic                i_out_ready      = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_grant_handle;
    logic [CLASS_W-1:0]  o_grant_class;

    int                  fail_count;
    int                  outstanding;
    int                  sent_count    = 0;
    int                  tx_idle_pct   = 0;
    int                  rx_stall_pct  = 0;
    int                  hold_off_asks = 0;
    logic [HANDLE_W-1:0] live_handles [$];

    always #1 i_clk = ~i_clk;

    size_class_free_list_allocator i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_req_size       (i_req_size),
        .i_handle_present (i_handle_present),
        .i_free_handle    (i_free_handle),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_grant_handle   (o_grant_handle),
        .o_grant_class    (o_grant_class)
    );

    free_list_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_in_valid),
        .i_req_ready      (o_in_ready),
        .i_cmd            (i_cmd),
        .i_req_size       (i_req_size),
        .i_handle_present (i_handle_present),
        .i_free_handle    (i_free_handle),
        .i_res_valid      (o_out_valid),
        .i_res_ready      (i_out_ready),
        .i_status         (o_status),
        .i_grant_handle   (o_grant_handle),
        .i_grant_class    (o_grant_class),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // Granted handles are collected so that most frees return a block really in use.
    // Inputs only change at rising edges, so a handshake seen here completes at the next one.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready && o_status == ST_GRANTED) begin
            live_handles.push_back(o_grant_handle);
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    initial begin : result_sink
        int stall_left;
        int asks_seen;
        stall_left = 0;
        asks_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asks != asks_seen) begin
                asks_seen  = hold_off_asks;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input logic cmd, input logic [SIZE_W-1:0] sz,
                                input logic present, input logic [HANDLE_W-1:0] h);
        int gap;
        bit taken;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= cmd;
        i_req_size       <= sz;
        i_handle_present <= present;
        i_free_handle    <= h;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        sent_count++;
        // Rotate through the idling patterns in stretches of requests.
        case ((sent_count / DIRECTED_PHASE_LEN) % 4)
            0: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1: begin
                tx_idle_pct  = 57;
                rx_stall_pct = 0;
            end
            2: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 57;
            end
            default: begin
                tx_idle_pct  = 29;
                rx_stall_pct = 29;
            end
        endcase
    endtask

    initial begin : stimulus
        int                  n;
        int                  pick;
        int                  s;
        int                  idx;
        logic                cmd;
        logic [SIZE_W-1:0]   sz;
        logic                present;
        logic [HANDLE_W-1:0] h;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the class boundaries at 16, 256, 512, 768 and 1024, the odd sizes and the odd frees.
        send_request(CMD_ALLOC, 32'd0, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd1, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd16, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd17, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd256, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd257, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd512, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd513, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd768, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd769, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd1024, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd1025, 1'b1, '1);
        send_request(CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, '1);
        // An empty small class borrows from the next larger class that has blocks.
        send_request(CMD_ALLOC, 32'd48, 1'b0, '0);
        send_request(CMD_FREE, 32'd0, 1'b0, '0);
        send_request(CMD_FREE, 32'hFFFF_FFFF, 1'b0, '1);
        // The large-size check wins over an unknown handle.
        send_request(CMD_FREE, 32'd2000, 1'b1, 12'd4000);
        send_request(CMD_FREE, 32'd100, 1'b1, 12'd4095);
        // The freed size is ignored; the block goes back to its chunk's class.
        send_request(CMD_FREE, 32'd1, 1'b1, 12'd320);
        send_request(CMD_FREE, 32'd16, 1'b1, 12'd1);
        send_request(CMD_FREE, 32'd16, 1'b1, 12'd1);
        send_request(CMD_ALLOC, 32'd16, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd1, 1'b0, '0);
        send_request(CMD_ALLOC, 32'd1000, 1'b0, '0);
        send_request(CMD_FREE, 32'd32, 1'b1, 12'd64);

        // Carve a run of chunks through the top class.
        hold_off_asks++;
        for (n = 0; n < DRAIN_ITEMS; n++) begin
            send_request(CMD_ALLOC, $urandom_range(1024, 769), 1'($urandom_range(1, 0)),
                         HANDLE_W'($urandom()));
        end

        hold_off_asks++;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick    = $urandom_range(99);
            present = 1'b1;
            h       = HANDLE_W'($urandom());
            sz      = $urandom_range(1024, 0);
            if (pick < 45 || (pick < 88 && live_handles.size() == 0)) begin
                cmd = CMD_ALLOC;
                s   = $urandom_range(99);
                if (s < 5) begin
                    sz = '0;
                end else if (s < 10) begin
                    sz = $urandom_range(32'hFFFF_FFFF, 32'd1025);
                end else if (s < 25) begin
                    sz = ($urandom_range(1, 0) ? $urandom_range(16, 1) * 16
                                               : $urandom_range(4, 2) * 256)
                         + $urandom_range(1, 0);
                end else begin
                    sz = $urandom_range(1024, 1);
                end
                present = 1'($urandom_range(1, 0));
            end else begin
                cmd = CMD_FREE;
                if (pick < 88) begin
                    idx = $urandom_range(live_handles.size() - 1, 0);
                    h   = live_handles[idx];
                    live_handles.delete(idx);
                end else if (pick < 92) begin
                    present = 1'b0;
                    sz      = $urandom();
                end else if (pick < 96) begin
                    sz = $urandom_range(32'hFFFF_FFFF, 32'd1025);
                end
            end
            send_request(cmd, sz, present, h);
        end
        i_in_valid <= 1'b0;

        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
